@@ rtl/m4inv_pkg.sv @@
// m4inv_pkg: types, constants and helper functions for the 4x4 matrix inverse core.
// Used by every module under rtl/; depends on nothing.
`timescale 1ns / 1ps

package m4inv_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int EW         = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;
  localparam int RECIP_BITS = 62;
  localparam int DIV_W      = 64;

  // sequencer step limits
  localparam int NUM_TERMS     = 6;
  localparam int COF_STEP_LAST = 4;
  localparam int DET_STEP_LAST = 8;
  localparam int OUT_STEP_LAST = 4;
  localparam int LAST_POS      = 15;

  typedef struct packed {
    logic [3:0]         elem_index;
    logic signed [31:0] elem_value;
    logic               last_element;
  } load_t;

  typedef struct packed {
    logic [3:0]         out_index;
    logic signed [31:0] out_value;
    logic               singular;
    logic               last_result;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COF,
    ST_COF_FIN,
    ST_DET,
    ST_DET_FIN,
    ST_RECIP,
    ST_DIV,
    ST_OUT_MUL,
    ST_OUT_FIN
  } state_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_32,
    SH_64
  } acc_shift_t;

  typedef struct packed {
    logic       acc_en;
    logic       first;
    logic       neg;
    acc_shift_t shift;
  } mul_ctl_t;

  // column of the 3x3 minor used by row k of triple product t (a permutation)
  function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] k);
    logic [5:0] p;
    case (t)
      3'd0:    p = {2'd0, 2'd1, 2'd2};
      3'd1:    p = {2'd0, 2'd2, 2'd1};
      3'd2:    p = {2'd1, 2'd0, 2'd2};
      3'd3:    p = {2'd1, 2'd2, 2'd0};
      3'd4:    p = {2'd2, 2'd0, 2'd1};
      3'd5:    p = {2'd2, 2'd1, 2'd0};
      default: p = '0;
    endcase
    case (k)
      2'd0:    return p[5:4];
      2'd1:    return p[3:2];
      default: return p[1:0];
    endcase
  endfunction

  // odd permutations carry a minus sign
  function automatic logic perm_neg(input logic [2:0] t);
    return (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
  endfunction

  // n-th member of {0,1,2,3} with excl removed
  function automatic logic [1:0] skip_one(input logic [1:0] n, input logic [1:0] excl);
    return (n >= excl) ? 2'(n + 2'd1) : n;
  endfunction

  function automatic logic signed [32:0] sx33(input logic signed [EW-1:0] v);
    return 33'(v);
  endfunction

  // floor(a / 2^s + 1/2), saturated to n signed bits, returned sign-extended to 64
  function automatic logic signed [63:0] rnd_sat(input logic signed [127:0] a,
                                                 input int unsigned s,
                                                 input int unsigned n);
    logic signed [127:0] sum;
    logic signed [127:0] sh;
    logic signed [127:0] top;
    sum = a + (128'sd1 <<< (s - 1));
    sh  = sum >>> s;
    top = sh >>> (n - 1);
    if (top == '0 || top == '1) begin
      return sh[63:0];
    end else if (sh[127]) begin
      return {64{1'b1}} << (n - 1);
    end else begin
      return (64'd1 << (n - 1)) - 64'd1;
    end
  endfunction

endpackage

@@ rtl/mat4_inverse_core.sv @@
// mat4_inverse_core: 4x4 Q16.16 matrix inverse by the adjugate, top level.
// Depends on m4inv_pkg, m4inv_mul and m4inv_div.
//
//   channel  signals                          payload
//   load     load_valid / load_ready          load_data  (m4inv_pkg::load_t)
//   result   res_valid  / res_ready           res_data   (m4inv_pkg::result_t)
//
// A load without the last mark is only stored; load_ready is high whenever idle.
// After the last mark: the 16 cofactors, the determinant, the reciprocal from the
// bit-serial divider, then the results, all but the reciprocal on the single shared
// 33x33 multiplier; a zero determinant skips to zero results marked singular.
// Reset clears the matrix store to zero. A result not taken holds the sequencer;
// the next load is taken while the sixteenth result still waits.
`timescale 1ns / 1ps

module mat4_inverse_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load_valid,
  output logic                 load_ready,
  input  m4inv_pkg::load_t     load_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output m4inv_pkg::result_t   res_data
);

  localparam int EW = m4inv_pkg::EW;
  localparam int F  = m4inv_pkg::FRAC_BITS;

  m4inv_pkg::state_t state, state_next;

  logic signed [EW-1:0] store [16];
  logic signed [63:0]   adj [16];
  logic [3:0]           step;
  logic [2:0]           term_k;
  logic [3:0]           idx;
  logic                 sing;

  logic signed [EW-1:0]  hold;
  logic signed [63:0]    yz_prod;
  logic signed [127:0]   acc;
  logic signed [63:0]    det;
  logic signed [63:0]    recip;

  logic [3:0]            rd_addr;
  logic signed [EW-1:0]  rd_elem;
  logic [3:0]            adj_rd;
  logic signed [63:0]    adj_word;

  logic signed [32:0]    mul_a, mul_b;
  m4inv_pkg::mul_ctl_t   mul_ctl, mq_ctl;
  logic signed [65:0]    mq_prod;
  logic signed [127:0]   term_ext, term_sh, term;

  logic                  load_fire, out_free, res_load, div_start;
  logic                  div_busy, div_done;
  logic [63:0]           det_mag, div_num, div_quot;
  logic signed [63:0]    out_v;

  logic [1:0] cof_r, cof_c;
  logic [3:0] x_addr, y_addr, z_addr;
  logic       term_neg;

  assign load_ready = (state == m4inv_pkg::ST_IDLE);
  assign load_fire  = load_valid && load_ready;
  assign out_free   = !res_valid || res_ready;
  assign rd_elem    = store[rd_addr];
  assign adj_word   = adj[adj_rd];

  // minor addressing: drop column group cof_c from rows and row cof_r from columns
  assign cof_r    = idx[1:0];
  assign cof_c    = idx[3:2];
  assign x_addr   = {m4inv_pkg::skip_one(m4inv_pkg::perm_col(term_k, 2'd0), cof_r),
                     m4inv_pkg::skip_one(2'd0, cof_c)};
  assign y_addr   = {m4inv_pkg::skip_one(m4inv_pkg::perm_col(term_k, 2'd1), cof_r),
                     m4inv_pkg::skip_one(2'd1, cof_c)};
  assign z_addr   = {m4inv_pkg::skip_one(m4inv_pkg::perm_col(term_k, 2'd2), cof_r),
                     m4inv_pkg::skip_one(2'd2, cof_c)};
  assign term_neg = m4inv_pkg::perm_neg(term_k) ^ cof_r[0] ^ cof_c[0];

  assign det_mag   = det[63] ? (~det + 64'd1) : det;
  assign div_num   = (64'd1 << m4inv_pkg::RECIP_BITS) + (det_mag >> 1);
  assign div_start = (state == m4inv_pkg::ST_RECIP) && (det != '0);
  assign res_load  = (state == m4inv_pkg::ST_OUT_FIN) && out_free;
  assign out_v     = m4inv_pkg::rnd_sat(acc, m4inv_pkg::RECIP_BITS - F, EW);

  m4inv_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .a        (mul_a),
    .b        (mul_b),
    .ctl      (mul_ctl),
    .prod     (mq_prod),
    .prod_ctl (mq_ctl)
  );

  m4inv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (det_mag),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      m4inv_pkg::ST_IDLE: begin
        if (load_fire && load_data.last_element) state_next = m4inv_pkg::ST_COF;
      end
      m4inv_pkg::ST_COF: begin
        if (step == 4'(m4inv_pkg::COF_STEP_LAST) &&
            term_k == 3'(m4inv_pkg::NUM_TERMS - 1)) begin
          state_next = m4inv_pkg::ST_COF_FIN;
        end
      end
      m4inv_pkg::ST_COF_FIN: begin
        state_next = (idx == 4'(m4inv_pkg::LAST_POS)) ? m4inv_pkg::ST_DET
                                                       : m4inv_pkg::ST_COF;
      end
      m4inv_pkg::ST_DET: begin
        if (step == 4'(m4inv_pkg::DET_STEP_LAST)) state_next = m4inv_pkg::ST_DET_FIN;
      end
      m4inv_pkg::ST_DET_FIN: state_next = m4inv_pkg::ST_RECIP;
      m4inv_pkg::ST_RECIP: begin
        state_next = (det == '0) ? m4inv_pkg::ST_OUT_FIN : m4inv_pkg::ST_DIV;
      end
      m4inv_pkg::ST_DIV: begin
        if (div_done) state_next = m4inv_pkg::ST_OUT_MUL;
      end
      m4inv_pkg::ST_OUT_MUL: begin
        if (step == 4'(m4inv_pkg::OUT_STEP_LAST)) state_next = m4inv_pkg::ST_OUT_FIN;
      end
      m4inv_pkg::ST_OUT_FIN: begin
        if (out_free) begin
          if (idx == 4'(m4inv_pkg::LAST_POS)) state_next = m4inv_pkg::ST_IDLE;
          else if (!sing) state_next = m4inv_pkg::ST_OUT_MUL;
        end
      end
      default: state_next = m4inv_pkg::ST_IDLE;
    endcase
  end

  // datapath controls: store/adjugate read addresses and multiplier operands
  always_comb begin
    rd_addr = '0;
    adj_rd  = idx;
    mul_a   = '0;
    mul_b   = '0;
    mul_ctl = '0;
    case (state)
      m4inv_pkg::ST_COF: begin
        case (step)
          4'd0: rd_addr = y_addr;
          4'd1: begin
            rd_addr = z_addr;
            mul_a   = m4inv_pkg::sx33(hold);
            mul_b   = m4inv_pkg::sx33(rd_elem);
          end
          4'd2: begin
            rd_addr         = x_addr;
            mul_a           = m4inv_pkg::sx33(rd_elem);
            mul_b           = {1'b0, mq_prod[31:0]};
            mul_ctl.acc_en  = 1'b1;
            mul_ctl.first   = (term_k == 3'd0);
            mul_ctl.neg     = term_neg;
            mul_ctl.shift   = m4inv_pkg::SH_0;
          end
          4'd3: begin
            rd_addr         = x_addr;
            mul_a           = m4inv_pkg::sx33(rd_elem);
            mul_b           = {yz_prod[63], yz_prod[63:32]};
            mul_ctl.acc_en  = 1'b1;
            mul_ctl.neg     = term_neg;
            mul_ctl.shift   = m4inv_pkg::SH_32;
          end
          default: rd_addr = x_addr;
        endcase
      end
      m4inv_pkg::ST_DET: begin
        rd_addr = {2'b00, step[2:1]};
        adj_rd  = {step[2:1], 2'b00};
        if (step < 4'(m4inv_pkg::DET_STEP_LAST)) begin
          mul_a          = m4inv_pkg::sx33(rd_elem);
          mul_b          = step[0] ? {adj_word[63], adj_word[63:32]}
                                   : {1'b0, adj_word[31:0]};
          mul_ctl.acc_en = 1'b1;
          mul_ctl.first  = (step == 4'd0);
          mul_ctl.shift  = step[0] ? m4inv_pkg::SH_32 : m4inv_pkg::SH_0;
        end
      end
      m4inv_pkg::ST_OUT_MUL: begin
        if (step < 4'(m4inv_pkg::OUT_STEP_LAST)) begin
          mul_a          = step[1] ? {adj_word[63], adj_word[63:32]}
                                   : {1'b0, adj_word[31:0]};
          mul_b          = step[0] ? {recip[63], recip[63:32]}
                                   : {1'b0, recip[31:0]};
          mul_ctl.acc_en = 1'b1;
          mul_ctl.first  = (step == 4'd0);
          case (step)
            4'd0:    mul_ctl.shift = m4inv_pkg::SH_0;
            4'd3:    mul_ctl.shift = m4inv_pkg::SH_64;
            default: mul_ctl.shift = m4inv_pkg::SH_32;
          endcase
        end
      end
      default: ;
    endcase
  end

  // partial product aligned and signed for the accumulator
  always_comb begin
    term_ext = 128'(mq_prod);
    case (mq_ctl.shift)
      m4inv_pkg::SH_32: term_sh = term_ext <<< 32;
      m4inv_pkg::SH_64: term_sh = term_ext <<< 64;
      default:          term_sh = term_ext;
    endcase
    term = mq_ctl.neg ? -term_sh : term_sh;
  end

  // control registers and matrix store
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= m4inv_pkg::ST_IDLE;
      step      <= '0;
      term_k    <= '0;
      idx       <= '0;
      sing      <= 1'b0;
      res_valid <= 1'b0;
      for (int i = 0; i < 16; i++) store[i] <= '0;
    end else begin
      state <= state_next;
      case (state)
        m4inv_pkg::ST_IDLE: begin
          if (load_fire) begin
            store[load_data.elem_index] <= load_data.elem_value[EW-1:0];
            idx    <= '0;
            term_k <= '0;
            step   <= '0;
          end
        end
        m4inv_pkg::ST_COF: begin
          if (step == 4'(m4inv_pkg::COF_STEP_LAST)) begin
            step   <= '0;
            term_k <= (term_k == 3'(m4inv_pkg::NUM_TERMS - 1)) ? 3'd0 : 3'(term_k + 3'd1);
          end else begin
            step <= step + 4'd1;
          end
        end
        m4inv_pkg::ST_COF_FIN: begin
          idx    <= idx + 4'd1;
          term_k <= '0;
          step   <= '0;
        end
        m4inv_pkg::ST_DET:     step <= step + 4'd1;
        m4inv_pkg::ST_DET_FIN: step <= '0;
        m4inv_pkg::ST_RECIP:   sing <= (det == '0);
        m4inv_pkg::ST_OUT_MUL: begin
          step <= (step == 4'(m4inv_pkg::OUT_STEP_LAST)) ? 4'd0 : step + 4'd1;
        end
        m4inv_pkg::ST_OUT_FIN: begin
          if (out_free) idx <= idx + 4'd1;
        end
        default: ;
      endcase
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    if (state == m4inv_pkg::ST_COF && step == 4'd0) hold <= rd_elem;
    if (state == m4inv_pkg::ST_COF && step == 4'd2) yz_prod <= mq_prod[63:0];
    if (mq_ctl.acc_en) acc <= mq_ctl.first ? term : acc + term;
    if (state == m4inv_pkg::ST_COF_FIN) adj[idx] <= m4inv_pkg::rnd_sat(acc, 2 * F, 64);
    if (state == m4inv_pkg::ST_DET_FIN) det <= m4inv_pkg::rnd_sat(acc, F, 64);
    if (state == m4inv_pkg::ST_DIV && div_done) begin
      recip <= det[63] ? -div_quot : div_quot;
    end
    if (res_load) begin
      res_data.out_index   <= idx;
      res_data.out_value   <= sing ? 32'sd0 : 32'(out_v);
      res_data.singular    <= sing;
      res_data.last_result <= (idx == 4'(m4inv_pkg::LAST_POS));
    end
  end

  a_last_on_fifteen: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.last_result == (res_data.out_index == 4'(m4inv_pkg::LAST_POS))))
    else $error("last_result does not match index fifteen");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.singular) |-> (res_data.out_value == 32'sd0))
    else $error("singular result with nonzero value");

  a_div_not_restarted: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_idle_no_accumulate: assert property (@(posedge clk) disable iff (rst)
    (state == m4inv_pkg::ST_IDLE) |-> !mq_ctl.acc_en)
    else $error("accumulate pending while idle");

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    (load_fire && load_data.last_element) |=> (state == m4inv_pkg::ST_COF && idx == 4'd0))
    else $error("inversion did not start at cofactor zero");

endmodule

@@ rtl/m4inv_mul.sv @@
// m4inv_mul: shared 33x33 signed multiplier with registered product.
// Carries the accumulate control alongside the product; uses m4inv_pkg.
`timescale 1ns / 1ps

module m4inv_mul (
  input  logic                   clk,
  input  logic                   rst,
  input  logic signed [32:0]     a,
  input  logic signed [32:0]     b,
  input  m4inv_pkg::mul_ctl_t    ctl,
  output logic signed [65:0]     prod,
  output m4inv_pkg::mul_ctl_t    prod_ctl
);

  logic signed [65:0] prod_next;

  assign prod_next = a * b;

  always_ff @(posedge clk) begin
    prod <= prod_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_ctl <= '0;
    end else begin
      prod_ctl <= ctl;
    end
  end

endmodule

@@ rtl/m4inv_div.sv @@
// m4inv_div: unsigned restoring divider, one quotient bit per cycle.
// Uses m4inv_pkg for the word width.
`timescale 1ns / 1ps

module m4inv_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [m4inv_pkg::DIV_W-1:0]  num,
  input  logic [m4inv_pkg::DIV_W-1:0]  den,
  output logic                         busy,
  output logic                         done,
  output logic [m4inv_pkg::DIV_W-1:0]  quot
);

  localparam int W  = m4inv_pkg::DIV_W;
  localparam int CW = $clog2(W);

  logic [W-1:0]  rem;
  logic [CW-1:0] cnt;
  logic [W:0]    rem_sh;
  logic [W+1:0]  diff;

  assign rem_sh = {rem, quot[W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= num;
    end else if (busy) begin
      if (!diff[W+1]) begin
        rem  <= diff[W-1:0];
        quot <= {quot[W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[W-1:0];
        quot <= {quot[W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ dv/mat4_inverse_checker.sv @@
// mat4_inverse_checker: watches the load and result channels of mat4_inverse_core,
// predicts each inverse from its own copy of the matrix store and compares.
// Depends on m4inv_pkg for the payload types.
`timescale 1ns / 1ps

module mat4_inverse_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               load_valid,
  input  logic               load_ready,
  input  m4inv_pkg::load_t   load_data,
  input  logic               res_valid,
  input  logic               res_ready,
  input  m4inv_pkg::result_t res_data,
  output int                 errors,
  output int                 pending,
  output int                 n_results,
  output int                 n_inversions,
  output int                 n_singular,
  output int                 n_saturated
);

  logic signed [31:0]  matrix_copy [16];
  m4inv_pkg::result_t  inverse_q [$];

  // floor(a / 2^s + 1/2), clamped to the signed n-bit range
  function automatic logic signed [63:0] round_clamp(input logic signed [127:0] a,
                                                     input int s, input int n);
    logic signed [127:0] sh;
    logic signed [127:0] lim;
    sh  = (a + (128'sd1 <<< (s - 1))) >>> s;
    lim = 128'sd1 <<< (n - 1);
    if (sh >= lim) return 64'(lim - 1);
    if (sh < -lim) return 64'(-lim);
    return sh[63:0];
  endfunction

  function automatic logic signed [63:0] cofactor(input int i);
    int                  r;
    int                  c;
    int                  rows [3];
    int                  cols [3];
    int                  n;
    logic signed [127:0] m [3][3];
    logic signed [127:0] acc;
    r = i % 4;
    c = i / 4;
    n = 0;
    for (int k = 0; k < 4; k++) if (k != c) begin rows[n] = k; n++; end
    n = 0;
    for (int k = 0; k < 4; k++) if (k != r) begin cols[n] = k; n++; end
    for (int x = 0; x < 3; x++)
      for (int y = 0; y < 3; y++)
        m[x][y] = 128'(matrix_copy[rows[x] + 4 * cols[y]]);
    acc = m[0][0] * m[1][1] * m[2][2] - m[0][0] * m[1][2] * m[2][1]
        - m[0][1] * m[1][0] * m[2][2] + m[0][1] * m[1][2] * m[2][0]
        + m[0][2] * m[1][0] * m[2][1] - m[0][2] * m[1][1] * m[2][0];
    if ((r + c) % 2 == 1) acc = -acc;
    return round_clamp(acc, 2 * m4inv_pkg::FRAC_BITS, 64);
  endfunction

  task automatic predict_inverse();
    logic signed [63:0]  adj [16];
    logic signed [127:0] acc;
    logic signed [63:0]  det;
    logic signed [63:0]  recip;
    logic [63:0]         mg;
    logic [63:0]         q;
    m4inv_pkg::result_t  res;
    for (int i = 0; i < 16; i++) adj[i] = cofactor(i);
    acc = '0;
    for (int j = 0; j < 4; j++) acc += 128'(matrix_copy[j]) * 128'(adj[4 * j]);
    det = round_clamp(acc, m4inv_pkg::FRAC_BITS, 64);
    recip = '0;
    if (det != 0) begin
      mg = det < 0 ? 64'(-det) : 64'(det);
      q = ((64'd1 << m4inv_pkg::RECIP_BITS) + (mg >> 1)) / mg;
      recip = det < 0 ? -$signed(q) : $signed(q);
    end
    for (int i = 0; i < 16; i++) begin
      res.out_index   = 4'(i);
      res.out_value   = (det == 0) ? '0 :
          32'(round_clamp(128'(adj[i]) * 128'(recip),
                          m4inv_pkg::RECIP_BITS - m4inv_pkg::FRAC_BITS, 32));
      res.singular    = (det == 0);
      res.last_result = (i == m4inv_pkg::LAST_POS);
      inverse_q.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    m4inv_pkg::result_t want;
    if (rst) begin
      for (int i = 0; i < 16; i++) matrix_copy[i] = '0;
      inverse_q.delete();
      errors = 0; n_results = 0; n_inversions = 0; n_singular = 0; n_saturated = 0;
    end else begin
      if (res_valid && res_ready) begin
        n_results++;
        if (res_data.singular) n_singular++;
        if (res_data.out_value == 32'sh7fffffff || res_data.out_value == 32'sh80000000)
          n_saturated++;
        if (inverse_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: unexpected result %p", $time, res_data);
        end else begin
          want = inverse_q.pop_front();
          if (res_data !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch, expected %p", $time, want);
              $display("%0t:           actual   %p", $time, res_data);
            end
          end
        end
      end
      if (load_valid && load_ready) begin
        matrix_copy[load_data.elem_index] = load_data.elem_value;
        if (load_data.last_element) begin
          n_inversions++;
          predict_inverse();
        end
      end
    end
    pending = inverse_q.size();
  end
endmodule

@@ dv/tb.sv @@
// tb: stimulus and verdict for mat4_inverse_core; checking is done by
// mat4_inverse_checker. Depends on m4inv_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               load_valid = 1'b0;
  logic               load_ready;
  m4inv_pkg::load_t   load_data = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  m4inv_pkg::result_t res_data;

  int errors, pending, n_results, n_inversions, n_singular, n_saturated;
  int n_loads = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mat4_inverse_core i_dut (
    .clk(clk), .rst(rst), .load_valid(load_valid), .load_ready(load_ready),
    .load_data(load_data), .res_valid(res_valid), .res_ready(res_ready),
    .res_data(res_data)
  );

  mat4_inverse_checker i_checker (
    .clk(clk), .rst(rst), .load_valid(load_valid), .load_ready(load_ready),
    .load_data(load_data), .res_valid(res_valid), .res_ready(res_ready),
    .res_data(res_data), .errors(errors), .pending(pending), .n_results(n_results),
    .n_inversions(n_inversions), .n_singular(n_singular), .n_saturated(n_saturated)
  );

  always @(posedge clk) begin
    res_ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  task automatic send(input logic [3:0] idx, input logic [31:0] val, input logic last);
    m4inv_pkg::load_t d;
    d.elem_index = idx;
    d.elem_value = val;
    d.last_element = last;
    if ($urandom_range(99) < send_idle_pct) begin
      load_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    load_valid <= 1'b1;
    load_data  <= d;
    @(posedge clk);
    while (!load_ready) @(posedge clk);
    n_loads++;
  endtask

  task automatic drain();
    load_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // well-conditioned matrix: dominant diagonal, small off-diagonal terms
  task automatic send_matrix();
    int order [16];
    int p;
    logic [31:0] v;
    for (int i = 0; i < 16; i++) order[i] = i;
    order.shuffle();
    for (int i = 0; i < 16; i++) begin
      p = order[i];
      if (p % 5 == 0) begin
        v = $urandom_range(32'h4_0000, 32'h1_0000);
        if ($urandom_range(1)) v = -v;
      end else begin
        v = $urandom_range(32'h1_0000) - 32'h8000;
      end
      send(4'(p), v, i == 15);
    end
  endtask

  task automatic random_phase(input int n_items);
    int start;
    int n;
    start = n_loads;
    while (n_loads - start < n_items) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5, 6: send_matrix();
        7: begin
          n = $urandom_range(4, 1);
          for (int i = 0; i < n; i++)
            send(4'($urandom_range(15)), $urandom_range(32'h2_0000) - 32'h1_0000, i == n - 1);
        end
        default: begin
          n = $urandom_range(6, 1);
          for (int i = 0; i < n; i++)
            send(4'($urandom_range(15)), $urandom(), $urandom_range(7) == 0);
        end
      endcase
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all-zero store after reset is singular
    send(4'd5, 32'h0, 1'b1);
    // identity
    send(4'd0, 32'h1_0000, 1'b0);
    send(4'd5, 32'h1_0000, 1'b0);
    send(4'd10, 32'h1_0000, 1'b0);
    send(4'd15, 32'h1_0000, 1'b1);
    // one negative diagonal entry, kept store with one entry changed
    send(4'd10, 32'hFFFE_0000, 1'b1);
    // extreme element values
    send(4'd0, 32'h7FFF_FFFF, 1'b0);
    send(4'd15, 32'h8000_0000, 1'b1);
    // tiny determinant: rounds to zero, so the result is singular
    send(4'd0, 32'h1, 1'b0);
    send(4'd5, 32'h1, 1'b0);
    send(4'd10, 32'h1, 1'b0);
    send(4'd15, 32'hFFFF_FFFF, 1'b1);
    // duplicate rows give a zero determinant
    send(4'd1, 32'h1, 1'b0);
    send(4'd4, 32'h1, 1'b0);
    send(4'd0, 32'h1, 1'b1);
    // full-range noise across all positions
    for (int i = 0; i < 16; i++) send(4'(i), $urandom(), i == 15);
    drain();

    random_phase(40);
    drain();
    send_idle_pct = 88;
    random_phase(40);
    send_idle_pct = 0;
    stall_pct = 88;
    random_phase(40);
    send_idle_pct = 21;
    stall_pct = 21;
    random_phase(40);
    drain();
    stall_pct = 0;
    repeat (100) @(posedge clk);

    $display("Covered %0d loads, %0d inversions, %0d results checked",
             n_loads, n_inversions, n_results);
    $display("(%0d singular results, %0d saturated values)", n_singular, n_saturated);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding", pending);
    $display("TEST FAILED");
    $finish;
  end
endmodule
